### rtl/hrb_pkg.sv
`default_nettype none

package hrb_pkg;

    // Operation codes carried in the low bits of the input transaction
    localparam logic [1:0] OP_INSERT      = 2'd0;
    localparam logic [1:0] OP_READ_NEWEST = 2'd1;
    localparam logic [1:0] OP_READ_OLDEST = 2'd2;
    localparam logic [1:0] OP_CLEAR       = 2'd3;

    localparam int FIELD_W   = 32;
    localparam int POS_W     = 4;
    localparam int HELD_W    = 5;
    localparam int ENTRY_W   = 3 * FIELD_W;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 104;

    // One stored history entry
    typedef struct packed {
        logic signed [FIELD_W-1:0] item_index;
        logic signed [FIELD_W-1:0] source;
        logic signed [FIELD_W-1:0] flag;
    } entry_t;

endpackage

`default_nettype wire

### rtl/history_ring_buffer.sv
// Channel  Dir  Bits   Contents (lowest bit first)
// s_       in   104    op[1:0] flag_in[33:2] source_in[65:34] item_index_in[97:66]
//                      position[101:98], zero pad
// m_       out  104    found[0] flag_out[32:1] source_out[64:33] item_index_out[96:65]
//                      entries_held[101:97], zero pad
//
// One transaction per cycle while s_tready is high; its result appears in the cycle after acceptance.
// The result register sits behind the single storage port (one write or one read).
// Reset clears the write pointer, the entry count and the output valid; stored
// entries are not cleared and are never read before written.
// s_tready drops only while a result is held and m_tready is low.
`default_nettype none

module history_ring_buffer #(
    parameter int DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // op, flag_in, source_in, item_index_in, position
    input  wire logic [hrb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found, flag_out, source_out, item_index_out, entries_held
    output logic [hrb_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                         accept;
    logic [1:0]                   op;
    logic [hrb_pkg::POS_W-1:0]    position;
    hrb_pkg::entry_t              wr_data, rd_data, out_data;
    logic                         wr_en, rd_en, found;
    logic [AW-1:0]                addr;
    logic [hrb_pkg::HELD_W-1:0]   entries_held;

    logic                         m_valid_reg;
    logic                         found_reg;
    logic [hrb_pkg::HELD_W-1:0]   held_reg;

    // Input field unpacking
    assign op                 = s_tdata[1:0];
    assign wr_data.flag       = s_tdata[33:2];
    assign wr_data.source     = s_tdata[65:34];
    assign wr_data.item_index = s_tdata[97:66];
    assign position           = s_tdata[101:98];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hrb_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (op),
        .position     (position),
        .wr_en        (wr_en),
        .rd_en        (rd_en),
        .addr         (addr),
        .found        (found),
        .entries_held (entries_held)
    );

    hrb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Result register; read data itself lives in the store's output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            found_reg <= found;
            held_reg  <= entries_held;
        end
    end

    // Data fields read as zero when nothing was found
    assign out_data = found_reg ? rd_data : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, held_reg, out_data.item_index, out_data.source,
                       out_data.flag, found_reg};

endmodule

`default_nettype wire

### rtl/hrb_ctrl.sv
`default_nettype none

module hrb_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [1:0]                  op,
    input  wire logic [hrb_pkg::POS_W-1:0]   position,
    output logic                             wr_en,
    output logic                             rd_en,
    output logic [AW-1:0]                    addr,
    output logic                             found,
    output logic [hrb_pkg::HELD_W-1:0]       entries_held
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int BASEW = (CW > hrb_pkg::POS_W) ? CW : hrb_pkg::POS_W;
    localparam int SW    = BASEW + 1;

    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;

    logic [SW-1:0] wp_w, pos_w, cnt_w, depth_w, sum_w, addr_w;
    logic          is_read;
    logic [31:0]   count_ext;

    assign wp_w    = SW'(wp_reg);
    assign pos_w   = SW'(position);
    assign cnt_w   = SW'(count_reg);
    assign depth_w = SW'(DEPTH);
    assign sum_w   = wp_w + pos_w;

    assign is_read = (op == hrb_pkg::OP_READ_NEWEST) || (op == hrb_pkg::OP_READ_OLDEST);
    assign found   = is_read && (pos_w < cnt_w);
    assign wr_en   = accept && (op == hrb_pkg::OP_INSERT);
    assign rd_en   = accept && found;

    // Ring address of the requested entry, wrapped without a divider
    always_comb begin
        if (op == hrb_pkg::OP_READ_NEWEST) begin
            if (wp_w > pos_w) begin
                addr_w = wp_w - pos_w - SW'(1);
            end else begin
                addr_w = wp_w + depth_w - SW'(1) - pos_w;
            end
        end else begin
            if (sum_w >= cnt_w) begin
                addr_w = sum_w - cnt_w;
            end else begin
                addr_w = sum_w + depth_w - cnt_w;
            end
        end
    end

    // Insert address is the write pointer itself
    assign addr = (op == hrb_pkg::OP_INSERT) ? wp_reg : addr_w[AW-1:0];

    // Pointer and count update
    always_comb begin
        wp_next    = wp_reg;
        count_next = count_reg;
        case (op)
            hrb_pkg::OP_INSERT: begin
                wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (count_reg != CW'(DEPTH)) begin
                    count_next = count_reg + CW'(1);
                end
            end
            hrb_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            count_reg <= '0;
        end else if (accept) begin
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    // Count after this operation, low bits only
    assign count_ext    = 32'(count_next);
    assign entries_held = count_ext[hrb_pkg::HELD_W-1:0];

endmodule

`default_nettype wire

### rtl/hrb_store.sv
`default_nettype none

module hrb_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   addr,
    input  wire hrb_pkg::entry_t wr_data,
    output hrb_pkg::entry_t      rd_data
);

    hrb_pkg::entry_t mem [DEPTH];
    hrb_pkg::entry_t rd_data_reg;

    // Single port: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/hrb_checker.sv
`default_nettype none

module hrb_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [hrb_pkg::M_TDATA_W-1:0]   m_tdata
);

    // A stalled result transaction stays valid and unchanged
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Miss or non-read results carry zero data
    a_zero_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[96:1] == '0)
        else $error("data nonzero without a hit");

    // A hit needs a nonempty ring, and the count never passes the depth
    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[101:97] != 5'd0 || DEPTH > 31)
        else $error("hit reported on an empty ring");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[101:97]) <= 32'(DEPTH))
        else $error("entry count above depth");

endmodule

bind history_ring_buffer hrb_checker #(.DEPTH(DEPTH)) u_hrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
